### rtl/bpq_pkg.sv
// ----------------------------------------------------------------------------
// bpq_pkg: shared types and constants for the button press qualifier queue
// Field structs for both channels, register indexes, function codes and
// the small ring helper that the event queue uses.
// ----------------------------------------------------------------------------
package bpq_pkg;

	localparam int QUEUE_SLOTS  = 16;
	localparam int BUTTON_COUNT = 6;

	localparam int PTR_W     = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam int BTN_IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

	localparam int DEBOUNCE_W  = 10;
	localparam int LONG_W      = 16;
	localparam int VERY_LONG_W = 20;
	localparam int CFG_DATA_W  = 20;
	localparam int CFG_INDEX_W = 2;
	localparam int TIME_W      = 32;
	localparam int BUTTON_W    = 3;

	localparam logic [DEBOUNCE_W-1:0]  DEBOUNCE_RESET  = DEBOUNCE_W'(30);
	localparam logic [LONG_W-1:0]      LONG_RESET      = LONG_W'(1000);
	localparam logic [VERY_LONG_W-1:0] VERY_LONG_RESET = VERY_LONG_W'(10000);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONG      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_VERY_LONG = 2'd2;

	// Input function codes; the fourth code is ignored.
	localparam logic [1:0] FUNC_EDGE   = 2'd0;
	localparam logic [1:0] FUNC_POP    = 2'd1;
	localparam logic [1:0] FUNC_INJECT = 2'd2;

	localparam logic [BUTTON_W-1:0] BUTTON_NONE = '0;

	typedef struct packed {
		logic [1:0]          func;
		logic [BUTTON_W-1:0] button_num;
		logic                pressed;
		logic [TIME_W-1:0]   time_ms;
	} item_t;

	typedef struct packed {
		logic                event_valid;
		logic [BUTTON_W-1:0] event_button;
		logic                long_hold;
		logic                vlong_hold;
	} result_t;

	// One queued event as it sits in a slot.
	typedef struct packed {
		logic                vlong_hold;
		logic                long_hold;
		logic [BUTTON_W-1:0] button;
	} slot_t;

	// Push request from the qualifier or the inject path into the queue.
	typedef struct packed {
		logic  valid;
		slot_t entry;
	} push_t;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = p + PTR_W'(1);
		if (p == PTR_W'(QUEUE_SLOTS - 1)) begin
			n = '0;
		end
		return n;
	endfunction

endpackage

### rtl/bpq_qualifier.sv
// ----------------------------------------------------------------------------
// bpq_qualifier: per-button debounce and press tracking
// Filters edges against the last accepted edge of the same button, tracks
// one press at a time and requests a queue push when it is released.
// ----------------------------------------------------------------------------
module bpq_qualifier (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 edge_en,
	input  logic [bpq_pkg::BUTTON_W-1:0]         button_num,
	input  logic                                 pressed,
	input  logic [bpq_pkg::TIME_W-1:0]           time_ms,
	input  logic [bpq_pkg::DEBOUNCE_W-1:0]       debounce_window_ms,
	input  logic [bpq_pkg::LONG_W-1:0]           long_press_ms,
	input  logic [bpq_pkg::VERY_LONG_W-1:0]      very_long_press_ms,
	output bpq_pkg::push_t                       push
);
	import bpq_pkg::*;

	logic [TIME_W-1:0]    last_edge_q [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0] seen_q;
	logic                 active_q;
	logic [BUTTON_W-1:0]  held_q;
	logic [TIME_W-1:0]    start_q;

	logic [BTN_IDX_W-1:0] k;
	logic                 id_ok;
	logic [TIME_W-1:0]    since;
	logic                 bounce;
	logic                 take;
	logic                 start_track;
	logic                 release_track;
	logic [TIME_W-1:0]    held_time;

	always_comb begin
		k     = BTN_IDX_W'(button_num - BUTTON_W'(1));
		id_ok = (button_num != BUTTON_NONE) && (button_num <= BUTTON_W'(BUTTON_COUNT));
		// Time differences wrap modulo 2^32, so a plain subtraction does it.
		since  = time_ms - last_edge_q[k];
		bounce = seen_q[k] && (since < TIME_W'(debounce_window_ms));
		take   = edge_en && id_ok && !bounce;
		start_track   = take && !active_q && pressed;
		release_track = take && active_q && !pressed && (button_num == held_q);
		held_time     = time_ms - start_q;
		push.valid            = release_track;
		push.entry.button     = button_num;
		push.entry.long_hold  = held_time > TIME_W'(long_press_ms);
		push.entry.vlong_hold = held_time > TIME_W'(very_long_press_ms);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			active_q <= 1'b0;
			held_q   <= BUTTON_NONE;
		end else begin
			if (take) begin
				seen_q[k] <= 1'b1;
			end
			if (start_track) begin
				active_q <= 1'b1;
				held_q   <= button_num;
			end else if (release_track) begin
				active_q <= 1'b0;
				held_q   <= BUTTON_NONE;
			end
		end
	end

	// Edge times and the start time are only read once their flags say so.
	always_ff @(posedge clk) begin
		if (take) begin
			last_edge_q[k] <= time_ms;
		end
		if (start_track) begin
			start_q <= time_ms;
		end
	end

endmodule

### rtl/bpq_queue.sv
// ----------------------------------------------------------------------------
// bpq_queue: ring queue of qualified button events
// One slot is kept free to tell full from empty. Pushes to a full queue are
// dropped; a pop of an empty queue returns an invalid event of zeros.
// ----------------------------------------------------------------------------
module bpq_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  bpq_pkg::push_t   push,
	input  logic             pop_en,
	output bpq_pkg::result_t pop_data
);
	import bpq_pkg::*;

	slot_t            slots_q [QUEUE_SLOTS];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic             full;
	logic             empty;
	logic             do_push;
	slot_t            head;

	always_comb begin
		full    = ring_next(wr_q) == rd_q;
		empty   = wr_q == rd_q;
		do_push = push.valid && !full;
		head    = slots_q[rd_q];
		if (empty) begin
			pop_data = '0;
		end else begin
			pop_data.event_valid  = 1'b1;
			pop_data.event_button = head.button;
			pop_data.long_hold    = head.long_hold;
			pop_data.vlong_hold   = head.vlong_hold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= ring_next(wr_q);
			end
			if (pop_en && !empty) begin
				rd_q <= ring_next(rd_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push.entry;
		end
	end

endmodule

### rtl/button_press_qualifier_queue.sv
// ----------------------------------------------------------------------------
// button_press_qualifier_queue: debounced long-press detector with event queue
// Takes button edges, pops and injected null events; qualified releases and
// injects are queued, and each pop returns one result.
// ----------------------------------------------------------------------------
//
//   channel   handshake                 payload
//   item      item_valid / item_stall   item   (func, button_num, pressed, time_ms)
//   result    result_valid / result_stall  result (event_valid, event_button,
//                                              long_hold, vlong_hold)
//   cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle while the result side does not stall: a transfer lands in the
// input register, is processed from there once the stage can advance, and a pop's
// result is then loaded into the result register.
// Reset clears the per-button flags, press tracking and queue pointers; the
// configuration registers return to 30, 1000 and 10000.
// A stalled result holds the stage behind it, which then stalls the item side.
module button_press_qualifier_queue (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  bpq_pkg::item_t                        item,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output bpq_pkg::result_t                      result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bpq_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [bpq_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import bpq_pkg::*;

	logic [DEBOUNCE_W-1:0]  debounce_q;
	logic [LONG_W-1:0]      long_q;
	logic [VERY_LONG_W-1:0] very_long_q;

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    edge_en;
	logic    pop_en;
	push_t   edge_push;
	push_t   push;
	result_t pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RESET;
			long_q      <= LONG_RESET;
			very_long_q <= VERY_LONG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEBOUNCE:  debounce_q  <= cfg_data[DEBOUNCE_W-1:0];
				CFG_LONG:      long_q      <= cfg_data[LONG_W-1:0];
				CFG_VERY_LONG: very_long_q <= cfg_data[VERY_LONG_W-1:0];
				default: ;
			endcase
		end
	end

	// The stage moves on whenever the result register is free to take a result.
	always_comb begin
		advance    = valid_s1 && (!result_valid || !result_stall);
		item_stall = valid_s1 && !advance;
		edge_en    = advance && (item_s1.func == FUNC_EDGE);
		pop_en     = advance && (item_s1.func == FUNC_POP);
		push       = edge_push;
		if (advance && (item_s1.func == FUNC_INJECT)) begin
			push.valid = 1'b1;
			push.entry = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (pop_en) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (pop_en) begin
			result <= pop_data;
		end
	end

	bpq_qualifier u_qualifier (
		.clk                (clk),
		.arst_n             (arst_n),
		.edge_en            (edge_en),
		.button_num         (item_s1.button_num),
		.pressed            (item_s1.pressed),
		.time_ms            (item_s1.time_ms),
		.debounce_window_ms (debounce_q),
		.long_press_ms      (long_q),
		.very_long_press_ms (very_long_q),
		.push               (edge_push)
	);

	bpq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop_en   (pop_en),
		.pop_data (pop_data)
	);

	// A stall toward the item side only comes from a held stage.
	a_stall_needs_stage: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("item stall raised with an empty stage");

	// Every processed pop shows up as a result in the next cycle.
	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop_en |=> result_valid)
		else $error("processed pop did not produce a result");

	// An empty-queue result carries all zero fields.
	a_empty_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.event_valid) |->
			(result.event_button == BUTTON_NONE && !result.long_hold
			&& !result.vlong_hold))
		else $error("empty-queue result has nonzero fields");

	// The edge path and the inject path never push in the same cycle.
	a_single_push: assert property (@(posedge clk) disable iff (!arst_n)
		edge_push.valid |-> (item_s1.func == FUNC_EDGE))
		else $error("edge push outside an edge item");

endmodule

### tb/sv/button_press_qualifier_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_press_qualifier_queue_tb: self-checking bench for the press qualifier
// Drives button edges, pops and injects, and mirrors the debounce, press
// tracking and event ring in a local predictor. Each popped result is checked
// in order, under random idling, back-pressure and several threshold settings.
// ----------------------------------------------------------------------------
module button_press_qualifier_queue_tb;
	import bpq_pkg::*;

	localparam int          MAX_WAIT      = 12;
	localparam int          DRAIN_CYCLES  = 6;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          PHASE_ITEMS   = 110;
	localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
	localparam logic [2:0]  BUTTON_BEYOND = BUTTON_W'(BUTTON_COUNT + 1);

	logic                    clk;
	logic                    arst_n;
	logic                    item_valid;
	logic                    item_stall;
	item_t                   item;
	logic                    result_valid;
	logic                    result_stall;
	result_t                 result;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	// Predictor state: thresholds, per-button debounce, press tracking, event ring.
	logic [DEBOUNCE_W-1:0]   cfg_debounce;
	logic [LONG_W-1:0]       cfg_long;
	logic [VERY_LONG_W-1:0]  cfg_very_long;
	logic [TIME_W-1:0]       last_taken_ms [1:BUTTON_COUNT];
	bit                      seen_flag [1:BUTTON_COUNT];
	bit                      tracking;
	logic [BUTTON_W-1:0]     tracked_button;
	logic [TIME_W-1:0]       press_t0;
	slot_t                   event_ring [QUEUE_SLOTS];
	int                      wr_ptr;
	int                      rd_ptr;

	result_t                 pending_events [$];
	logic [TIME_W-1:0]       now_ms;
	bit                      tx_idle;
	bit                      rx_idle;
	int                      hold_left;
	int                      items_sent;
	int                      results_checked;
	int                      settings_used;
	int                      mismatch_count;

	button_press_qualifier_queue u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic void clear_predictor();
		cfg_debounce   = DEBOUNCE_RESET;
		cfg_long       = LONG_RESET;
		cfg_very_long  = VERY_LONG_RESET;
		for (int b = 1; b <= BUTTON_COUNT; b++) begin
			last_taken_ms[b] = '0;
			seen_flag[b]     = 1'b0;
		end
		tracking       = 1'b0;
		tracked_button = BUTTON_NONE;
		press_t0       = '0;
		wr_ptr         = 0;
		rd_ptr         = 0;
	endfunction

	// One slot always stays free, so a push that would meet the read side is dropped.
	function automatic void push_event(input logic [BUTTON_W-1:0] btn, input logic lng,
			input logic vlng);
		int nxt;
		nxt = (wr_ptr + 1) % QUEUE_SLOTS;
		if (nxt != rd_ptr) begin
			event_ring[wr_ptr].button     = btn;
			event_ring[wr_ptr].long_hold  = lng;
			event_ring[wr_ptr].vlong_hold = vlng;
			wr_ptr = nxt;
		end
	endfunction

	function automatic bit qualify_and_queue(input item_t it, output result_t popped);
		logic [TIME_W-1:0] since_last;
		logic [TIME_W-1:0] held;
		int                k;
		bit                has_result;
		popped     = '0;
		has_result = 1'b0;
		case (it.func)
			FUNC_EDGE: begin
				if (it.button_num != BUTTON_NONE && it.button_num <= BUTTON_COUNT) begin
					k          = int'(it.button_num);
					since_last = it.time_ms - last_taken_ms[k];
					if (!(seen_flag[k] && since_last < TIME_W'(cfg_debounce))) begin
						seen_flag[k]     = 1'b1;
						last_taken_ms[k] = it.time_ms;
						if (!tracking && it.pressed) begin
							tracking       = 1'b1;
							tracked_button = it.button_num;
							press_t0       = it.time_ms;
						end else if (tracking && !it.pressed && it.button_num == tracked_button) begin
							held = it.time_ms - press_t0;
							push_event(it.button_num, held > TIME_W'(cfg_long),
								held > TIME_W'(cfg_very_long));
							tracking       = 1'b0;
							tracked_button = BUTTON_NONE;
						end
					end
				end
			end
			FUNC_POP: begin
				has_result = 1'b1;
				if (rd_ptr != wr_ptr) begin
					popped.event_valid  = 1'b1;
					popped.event_button = event_ring[rd_ptr].button;
					popped.long_hold    = event_ring[rd_ptr].long_hold;
					popped.vlong_hold   = event_ring[rd_ptr].vlong_hold;
					rd_ptr = (rd_ptr + 1) % QUEUE_SLOTS;
				end
			end
			FUNC_INJECT: push_event(BUTTON_NONE, 1'b0, 1'b0);
			default: ;
		endcase
		return has_result;
	endfunction

	// ------------------------------------------------------------------------
	// Result side: random stall per result plus an optional long hold-off
	// ------------------------------------------------------------------------
	initial begin
		int rx_wait;
		rx_wait      = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid === 1'b1 && !result_stall) begin
				rx_wait = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid === 1'b1 && !result_stall) begin
			if (pending_events.size() == 0) begin
				$error("Result transfer with no pop outstanding");
				mismatch_count++;
			end else begin
				want = pending_events.pop_front();
				check_field("event_valid", 32'(want.event_valid), 32'(result.event_valid));
				check_field("event_button", 32'(want.event_button),
					32'(result.event_button));
				check_field("long_hold", 32'(want.long_hold), 32'(result.long_hold));
				check_field("vlong_hold", 32'(want.vlong_hold), 32'(result.vlong_hold));
				results_checked++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Item side
	// ------------------------------------------------------------------------
	// Valid stays high on return so that a back-to-back item needs no extra
	// assignment; anything else that lets time pass lowers it first.
	task automatic send_item(input item_t it);
		int      gap;
		result_t popped;
		gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		items_sent++;
		if (qualify_and_queue(it, popped)) begin
			pending_events.push_back(popped);
		end
	endtask

	task automatic send_edge(input logic [BUTTON_W-1:0] btn, input logic prs,
			input logic [TIME_W-1:0] t);
		item_t it;
		it.func       = FUNC_EDGE;
		it.button_num = btn;
		it.pressed    = prs;
		it.time_ms    = t;
		send_item(it);
	endtask

	// Pops and injects carry random filler in the fields they do not use.
	task automatic send_code(input logic [1:0] code);
		item_t it;
		it.func       = code;
		it.button_num = BUTTON_W'($urandom_range(0, 7));
		it.pressed    = 1'($urandom_range(0, 1));
		it.time_ms    = $urandom;
		send_item(it);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_thresholds(input logic [CFG_DATA_W-1:0] deb,
			input logic [CFG_DATA_W-1:0] lng, input logic [CFG_DATA_W-1:0] vlng);
		logic [CFG_INDEX_W-1:0] idx [3];
		logic [CFG_DATA_W-1:0]  val [3];
		idx = '{CFG_DEBOUNCE, CFG_LONG, CFG_VERY_LONG};
		val = '{deb, lng, vlng};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				CFG_DEBOUNCE:  cfg_debounce  = val[i][DEBOUNCE_W-1:0];
				CFG_LONG:      cfg_long      = val[i][LONG_W-1:0];
				CFG_VERY_LONG: cfg_very_long = val[i][VERY_LONG_W-1:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// A press with contact bounce, an occasional stray edge of a random button,
	// a release that is sometimes placed around a threshold, a few pops and at times an inject.
	task automatic press_sequence();
		logic [BUTTON_W-1:0] btn;
		logic [TIME_W-1:0]   t0;
		logic [TIME_W-1:0]   hold;
		btn    = BUTTON_W'($urandom_range(1, BUTTON_COUNT));
		now_ms = now_ms + $urandom_range(0, 3 * cfg_debounce + 50);
		t0     = now_ms;
		send_edge(btn, 1'b1, t0);
		repeat ($urandom_range(0, 2)) begin
			now_ms = now_ms + $urandom_range(0, cfg_debounce);
			send_edge(btn, 1'($urandom_range(0, 1)), now_ms);
		end
		if ($urandom_range(0, 3) == 0) begin
			send_edge(BUTTON_W'($urandom_range(1, BUTTON_COUNT)), 1'($urandom_range(0, 1)),
				now_ms + $urandom_range(0, 100));
		end
		case ($urandom_range(0, 5))
			0:       hold = TIME_W'(cfg_long) + $urandom_range(0, 4) - 32'd2;
			1:       hold = TIME_W'(cfg_very_long) + $urandom_range(0, 4) - 32'd2;
			2:       hold = $urandom_range(0, cfg_long);
			3:       hold = $urandom_range(0, 2 * cfg_very_long + 10);
			4:       hold = $urandom_range(0, cfg_debounce);
			default: hold = $urandom;
		endcase
		now_ms = t0 + hold;
		send_edge(btn, 1'b0, now_ms);
		repeat ($urandom_range(0, 2)) send_code(FUNC_POP);
		if ($urandom_range(0, 7) == 0) begin
			send_code(FUNC_INJECT);
		end
	endtask

	task automatic noise_item();
		item_t it;
		it.func       = 2'($urandom_range(0, 3));
		it.button_num = BUTTON_W'($urandom_range(0, 7));
		it.pressed    = 1'($urandom_range(0, 1));
		it.time_ms    = $urandom;
		send_item(it);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed_cases();
		send_code(FUNC_POP);                          // empty queue
		send_edge(BUTTON_NONE, 1'b1, 32'd100);        // no button
		send_edge(BUTTON_BEYOND, 1'b1, 32'd100);      // beyond the last button
		send_code(FUNC_UNUSED);
		send_code(FUNC_INJECT);
		send_code(FUNC_POP);
		// A first edge is never debounced, even close to time zero.
		send_edge(3'd1, 1'b1, 32'd5);
		send_edge(3'd1, 1'b0, 32'd20);                // bounce, dropped
		send_edge(3'd2, 1'b1, 32'd25);                // second press while one is tracked
		send_edge(3'd2, 1'b0, 32'd60);                // release of an untracked button
		send_edge(3'd1, 1'b0, 32'd1005);              // exactly on the long threshold
		send_code(FUNC_POP);
		send_edge(3'd3, 1'b1, 32'd2000);
		send_edge(3'd3, 1'b0, 32'd3001);              // just above long
		send_edge(3'd4, 1'b1, 32'd5000);
		send_edge(3'd4, 1'b0, 32'd15001);             // just above very long
		send_code(FUNC_POP);
		send_code(FUNC_POP);
		// Holds that straddle the wrap of the millisecond counter.
		send_edge(3'd5, 1'b1, 32'hFFFF_FFF0);
		send_edge(3'd5, 1'b0, 32'h0000_0100);
		send_edge(3'd6, 1'b1, 32'hFFFF_FC00);
		send_edge(3'd6, 1'b0, 32'h0000_0400);
		send_code(FUNC_POP);
		send_code(FUNC_POP);
		send_code(FUNC_POP);
		wait_drained();
		now_ms = 32'h0001_0000;
	endtask

	task automatic test_queue_overflow();
		send_edge(3'd2, 1'b1, now_ms);
		repeat (QUEUE_SLOTS) send_code(FUNC_INJECT);
		now_ms = now_ms + 32'd2000;
		send_edge(3'd2, 1'b0, now_ms);                // lands on a full queue
		repeat (QUEUE_SLOTS) send_code(FUNC_POP);
		wait_drained();
	endtask

	// The result side holds off while items keep coming, so the pipeline
	// fills and the item side must stall; afterwards everything drains.
	task automatic test_result_backpressure();
		tx_idle   = 1'b0;
		hold_left = HOLD_CYCLES;
		repeat (6) send_code(FUNC_INJECT);
		repeat (24) send_code(FUNC_POP);
		wait_drained();
		tx_idle = 1'b1;
	endtask

	task automatic test_random_thresholds();
		int start;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					tx_idle = 1'b1; rx_idle = 1'b1;
					program_thresholds(20'd30, 20'd1000, 20'd10000);
					now_ms = $urandom;
				end
				1: begin
					tx_idle = 1'b0; rx_idle = 1'b0;
					program_thresholds('0, '0, '0);
				end
				2: begin
					tx_idle = 1'b1; rx_idle = 1'b1;
					program_thresholds('1, '1, '1);
					now_ms = 32'hFFF0_0000;
				end
				3: begin
					tx_idle = 1'b1; rx_idle = 1'b0;
					program_thresholds(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
						CFG_DATA_W'($urandom));
				end
				default: begin
					tx_idle = 1'b0; rx_idle = 1'b1;
					program_thresholds(CFG_DATA_W'($urandom_range(0, 100)),
						CFG_DATA_W'($urandom_range(0, 3000)),
						CFG_DATA_W'($urandom_range(0, 20000)));
				end
			endcase
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0) begin
					noise_item();
				end else begin
					press_sequence();
				end
			end
			wait_drained();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		item_valid      = 1'b0;
		item            = '0;
		cfg_valid       = 1'b0;
		cfg_index       = CFG_DEBOUNCE;
		cfg_data        = '0;
		tx_idle         = 1'b1;
		rx_idle         = 1'b1;
		hold_left       = 0;
		now_ms          = '0;
		items_sent      = 0;
		results_checked = 0;
		settings_used   = 0;
		mismatch_count  = 0;
		clear_predictor();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_queue_overflow();
		test_result_backpressure();
		test_random_thresholds();
		wait_drained();

		$display("Sent %0d items and checked %0d pop results across %0d threshold settings,",
			items_sent, results_checked, settings_used);
		$display("with debounce, long and very long holds, counter wrap, overflow and back-pressure.");
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
